>>> rtl/core/dcld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcld_pkg
// Shared types, codes and helpers of the delta count leaf decoder.
// ----------------------------------------------------------------------------
package dcld_pkg;

   // Result kinds
   localparam logic [1:0] KIND_ENTRY = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_TRUNC = 2'd2;

   // Header byte decoding
   localparam logic [7:0] HDR_FLAG_BYTE  = 8'h80;
   localparam logic [6:0] HDR_CODE_MASK  = 7'd127;
   localparam logic [6:0] HDR_REPEAT_MIN = 7'd25;
   localparam logic [3:0] GAP_MASK       = 4'd15;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Class of a byte when it is read as a header
   typedef enum logic [1:0] {
      HDR_ZERO,
      HDR_SMALL,
      HDR_FIELD,
      HDR_REPEAT
   } hdr_class_type;

   // Input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } dcld_req_type;

   // Result transaction
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] key_value;
      logic [31:0] entry_count;
      logic        page_end;
   } dcld_rsp_type;

   // Classified byte, as queued between front and back
   typedef struct packed {
      logic [7:0]    data_byte;
      logic          first_byte;
      logic          last_byte;
      logic          big_endian;
      hdr_class_type hdr_class;
      logic [2:0]    key_len;
      logic [2:0]    cnt_len;
   } dcld_item_type;

   // Split a field code below 25 into code/5 and code%5
   function automatic logic [5:0] split_code(input logic [4:0] code);
      logic [2:0] klen;
      logic [4:0] rem;
      begin
         if (code >= 5'd20) begin
            klen = 3'd4;
         end else if (code >= 5'd15) begin
            klen = 3'd3;
         end else if (code >= 5'd10) begin
            klen = 3'd2;
         end else if (code >= 5'd5) begin
            klen = 3'd1;
         end else begin
            klen = 3'd0;
         end
         rem = code - 5'(klen * 3'd5);
         split_code = {klen, rem[2:0]};
      end
   endfunction

endpackage

>>> rtl/core/dcld_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcld_front
// Accepts page bytes, holds the byte-order register and classifies each
// byte as a header so the back end only selects among ready-made fields.
// ----------------------------------------------------------------------------
module dcld_front import dcld_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dcld_req_type  req_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_wdata,
   input  logic          queue_full,
   output logic          push_valid,
   output dcld_item_type push_item
);

   logic       big_endian_ff;
   logic       big_endian_in;
   logic [6:0] code;
   logic [5:0] lens;

   // Byte-order register, always writable
   assign csr_ready     = 1'b1;
   assign big_endian_in = (csr_valid && csr_ready) ? csr_wdata : big_endian_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
      end else begin
         big_endian_ff <= big_endian_in;
      end
   end

   // Hold the input while the queue is full
   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   // Classify the byte as a header
   assign code = req_data.data_byte[6:0] & HDR_CODE_MASK;
   assign lens = split_code(code[4:0]);

   always_comb begin
      push_item.data_byte  = req_data.data_byte;
      push_item.first_byte = req_data.first_byte;
      push_item.last_byte  = req_data.last_byte;
      push_item.big_endian = big_endian_ff;
      push_item.key_len    = 3'd0;
      push_item.cnt_len    = 3'd0;
      if (req_data.data_byte == 8'd0) begin
         push_item.hdr_class = HDR_ZERO;
      end else if (req_data.data_byte < HDR_FLAG_BYTE) begin
         push_item.hdr_class = HDR_SMALL;
      end else if (code >= HDR_REPEAT_MIN) begin
         push_item.hdr_class = HDR_REPEAT;
      end else begin
         push_item.hdr_class = HDR_FIELD;
         push_item.key_len   = lens[5:3];
         push_item.cnt_len   = lens[2:0];
      end
   end

endmodule

>>> rtl/core/dcld_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcld_queue
// Short FIFO of classified bytes between the front and the back end.
// ----------------------------------------------------------------------------
module dcld_queue import dcld_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  dcld_item_type push_item,
   output logic          queue_full,
   output logic          pop_valid,
   input  logic          pop_ready,
   output dcld_item_type pop_item
);

   localparam logic [QCNT_W-1:0] FullCount = QCNT_W'(QUEUE_DEPTH);

   dcld_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_pop;

   assign queue_full = (count_ff == FullCount);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/dcld_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcld_back
// Runs the page decoder on queued bytes: leading words, headers and field
// bytes, and drives the registered result channel.
// ----------------------------------------------------------------------------
module dcld_back import dcld_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  dcld_item_type pop_item,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dcld_rsp_type  rsp_data
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEAD,
      PH_HEADER,
      PH_KEYF,
      PH_CNTF
   } phase_type;

   phase_type    phase_ff, phase_in, ph;
   logic [2:0]   lead_idx_ff, lead_idx_in, idx;
   logic [31:0]  key_ff, key_in, key_cur;
   logic [31:0]  cnt_ff, cnt_in, cnt_cur;
   logic [31:0]  field_ff, field_in, field_cur;
   logic [2:0]   kleft_ff, kleft_in, kleft_cur;
   logic [2:0]   cleft_ff, cleft_in, cleft_cur;
   logic         rsp_valid_ff, rsp_valid_in;
   dcld_rsp_type rsp_data_ff, rsp_data_in;

   logic         do_pop;
   logic         emit;
   dcld_rsp_type emit_data;
   logic [7:0]   b;
   logic         last;
   logic [31:0]  lead_word, lead_new;
   logic [31:0]  field_shift;
   logic [31:0]  key_addend;
   logic         key_carry;
   logic [31:0]  key_sum;
   logic [2:0]   kleft_dec, cleft_dec;

   assign pop_ready = !rsp_valid_ff || !rsp_stall;
   assign do_pop    = pop_valid && pop_ready;
   assign b         = pop_item.data_byte;
   assign last      = pop_item.last_byte;

   // Restart state on a page start
   always_comb begin
      if (pop_item.first_byte) begin
         ph        = PH_LEAD;
         idx       = 3'd0;
         key_cur   = '0;
         cnt_cur   = '0;
         field_cur = '0;
         kleft_cur = 3'd0;
         cleft_cur = 3'd0;
      end else begin
         ph        = phase_ff;
         idx       = lead_idx_ff;
         key_cur   = key_ff;
         cnt_cur   = cnt_ff;
         field_cur = field_ff;
         kleft_cur = kleft_ff;
         cleft_cur = cleft_ff;
      end
   end

   // Shared datapath pieces
   assign lead_word   = idx[2] ? cnt_cur : key_cur;
   assign lead_new    = pop_item.big_endian ? {lead_word[23:0], b}
                                            : lead_word | ({24'd0, b} << {idx[1:0], 3'd0});
   assign field_shift = {field_cur[23:0], b};
   assign kleft_dec   = kleft_cur - 3'd1;
   assign cleft_dec   = cleft_cur - 3'd1;
   assign key_sum     = key_cur + key_addend + {31'd0, key_carry};

   always_comb begin
      key_addend = '0;
      key_carry  = 1'b0;
      case (ph)
         PH_HEADER: begin
            if (pop_item.hdr_class == HDR_SMALL) begin
               key_addend = {28'd0, b[3:0] & GAP_MASK};
            end else begin
               key_carry = 1'b1;
            end
         end
         PH_KEYF: begin
            key_addend = field_shift;
            key_carry  = 1'b1;
         end
         default: begin
            key_addend = '0;
         end
      endcase
   end

   // Decode one byte
   always_comb begin
      phase_in    = ph;
      lead_idx_in = idx;
      key_in      = key_cur;
      cnt_in      = cnt_cur;
      field_in    = field_cur;
      kleft_in    = kleft_cur;
      cleft_in    = cleft_cur;
      emit        = 1'b0;
      emit_data   = '{kind: KIND_TRUNC, key_value: '0, entry_count: '0, page_end: 1'b1};

      case (ph)
         PH_LEAD: begin
            if (idx[2]) begin
               cnt_in = lead_new;
            end else begin
               key_in = lead_new;
            end
            if (idx == 3'd7) begin
               lead_idx_in = 3'd0;
               emit        = 1'b1;
               phase_in    = last ? PH_IDLE : PH_HEADER;
               emit_data   = '{kind: KIND_ENTRY, key_value: key_cur,
                               entry_count: lead_new, page_end: last};
            end else begin
               lead_idx_in = idx + 3'd1;
               if (last) begin
                  phase_in = PH_IDLE;
                  emit     = 1'b1;
               end
            end
         end
         PH_HEADER: begin
            case (pop_item.hdr_class)
               HDR_ZERO: begin
                  phase_in  = PH_IDLE;
                  emit      = 1'b1;
                  emit_data = '{kind: KIND_END, key_value: '0, entry_count: '0,
                                page_end: 1'b1};
               end
               HDR_SMALL: begin
                  key_in    = key_sum;
                  cnt_in    = {29'd0, b[6:4]} + 32'd1;
                  emit      = 1'b1;
                  phase_in  = last ? PH_IDLE : PH_HEADER;
                  emit_data = '{kind: KIND_ENTRY, key_value: key_sum,
                                entry_count: {29'd0, b[6:4]} + 32'd1, page_end: last};
               end
               HDR_REPEAT: begin
                  emit      = 1'b1;
                  phase_in  = last ? PH_IDLE : PH_HEADER;
                  emit_data = '{kind: KIND_ENTRY, key_value: key_cur,
                                entry_count: cnt_cur, page_end: last};
               end
               default: begin
                  kleft_in = pop_item.key_len;
                  cleft_in = pop_item.cnt_len;
                  field_in = '0;
                  if (pop_item.key_len == 3'd0) begin
                     key_in = key_sum;
                  end
                  if (pop_item.cnt_len == 3'd0) begin
                     cnt_in = 32'd1;
                  end
                  if (pop_item.key_len == 3'd0 && pop_item.cnt_len == 3'd0) begin
                     emit      = 1'b1;
                     phase_in  = last ? PH_IDLE : PH_HEADER;
                     emit_data = '{kind: KIND_ENTRY, key_value: key_sum,
                                   entry_count: 32'd1, page_end: last};
                  end else if (last) begin
                     phase_in = PH_IDLE;
                     emit     = 1'b1;
                  end else begin
                     phase_in = (pop_item.key_len != 3'd0) ? PH_KEYF : PH_CNTF;
                  end
               end
            endcase
         end
         PH_KEYF: begin
            field_in = field_shift;
            kleft_in = kleft_dec;
            if (kleft_dec == 3'd0) begin
               key_in   = key_sum;
               field_in = '0;
               if (cleft_cur == 3'd0) begin
                  cnt_in    = 32'd1;
                  emit      = 1'b1;
                  phase_in  = last ? PH_IDLE : PH_HEADER;
                  emit_data = '{kind: KIND_ENTRY, key_value: key_sum,
                                entry_count: 32'd1, page_end: last};
               end else begin
                  phase_in = PH_CNTF;
               end
            end
            if (last && !emit) begin
               phase_in = PH_IDLE;
               emit     = 1'b1;
            end
         end
         PH_CNTF: begin
            field_in = field_shift;
            cleft_in = cleft_dec;
            if (cleft_dec == 3'd0) begin
               cnt_in    = field_shift + 32'd1;
               field_in  = '0;
               emit      = 1'b1;
               phase_in  = last ? PH_IDLE : PH_HEADER;
               emit_data = '{kind: KIND_ENTRY, key_value: key_cur,
                             entry_count: field_shift + 32'd1, page_end: last};
            end else if (last) begin
               phase_in = PH_IDLE;
               emit     = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Result register: load on a new result, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (do_pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         lead_idx_ff  <= 3'd0;
         key_ff       <= '0;
         cnt_ff       <= '0;
         field_ff     <= '0;
         kleft_ff     <= 3'd0;
         cleft_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (do_pop) begin
            phase_ff    <= phase_in;
            lead_idx_ff <= lead_idx_in;
            key_ff      <= key_in;
            cnt_ff      <= cnt_in;
            field_ff    <= field_in;
            kleft_ff    <= kleft_in;
            cleft_ff    <= cleft_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_end_kinds_close_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind != KIND_ENTRY |-> rsp_data_ff.page_end)
      else $error("non-entry result without page end");

   a_end_kinds_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind != KIND_ENTRY
         |-> rsp_data_ff.key_value == '0 && rsp_data_ff.entry_count == '0)
      else $error("non-entry result carries key or count");

   a_page_end_idles: assert property (@(posedge clock) disable iff (reset)
      do_pop && emit && emit_data.page_end |=> phase_ff == PH_IDLE)
      else $error("decoder not idle after page end");

   a_keyf_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_KEYF |-> kleft_ff != 3'd0)
      else $error("key field phase with no bytes left");

   a_cntf_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CNTF |-> cleft_ff != 3'd0)
      else $error("count field phase with no bytes left");

endmodule

>>> rtl/core/delta_count_leaf_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_count_leaf_decoder
// Decodes compressed index pages, one byte per transaction, into
// (key, count) entries and page-end status.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one page byte per transaction, with first_byte on the page's
//            first byte and last_byte on its final byte.
//   rsp_*  : zero or one result per byte: an entry, a page end without entry
//            (zero header), or a truncated entry when the page ends early.
//   csr_*  : one-bit byte-order register for the two leading words; write it
//            only while no transaction is in flight. csr_ready is always high.
// Throughput is one byte per cycle while no result is held by rsp_stall:
// the back end retires a queued byte each cycle and its key update is a
// single 32-bit add. An accepted byte is written into the two-entry front
// queue, and the back end then loads the result register from it, where
// the result can be taken.
// When rsp_stall holds a result, the back end stops, the queue fills and
// req_stall rises once two bytes wait in the queue; no transaction is lost.
// Reset clears the queue, the result register and the decoder, which then
// waits for a byte with first_byte; the byte order returns to little-endian.
// ----------------------------------------------------------------------------
module delta_count_leaf_decoder import dcld_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dcld_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output dcld_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_wdata
);

   logic          queue_full;
   logic          push_valid;
   dcld_item_type push_item;
   logic          pop_valid;
   logic          pop_ready;
   dcld_item_type pop_item;

   // Accept and classify
   dcld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   // Decouple front and back
   dcld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Decode and emit
   dcld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
